### src/fdf_pkg.sv
// Package for the flood relay duplicate filter.
// Holds field widths, register indexes, reset values and the verdict codes.
// No dependencies; every other file in src imports it.
`default_nettype none

package fdf_pkg;

  // Field widths of one packet header word.
  localparam int BYTE_W = 8;
  localparam int ID_W   = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_SYSTEM_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = CFG_IDX_W'(1);

  localparam logic [BYTE_W-1:0] OWN_SYSTEM_ID_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] HEADER_LENGTH_RESET = 8'd8;

  // Message kind that clears the stored id of its source.
  localparam logic [BYTE_W-1:0] KIND_RESET_ID = 8'd9;

  localparam int NODE_COUNT_DEFAULT = 64;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_TOO_SHORT = 3'd1,
    VERDICT_OTHER_SYS = 3'd2,
    VERDICT_BAD_SRC   = 3'd3,
    VERDICT_NO_HOPS   = 3'd4,
    VERDICT_STALE     = 3'd5
  } verdict_t;

  // One packet header as it arrives on the input stream.
  typedef struct packed {
    logic [BYTE_W-1:0] message_kind;
    logic [ID_W-1:0]   message_number;
    logic [BYTE_W-1:0] hops_left;
    logic [BYTE_W-1:0] source_node;
    logic [BYTE_W-1:0] packet_system_id;
    logic [BYTE_W-1:0] packet_length;
  } hdr_t;

  // Decision for one header.
  typedef struct packed {
    verdict_t          verdict;
    logic [BYTE_W-1:0] hops_out;
    logic              forward;
  } result_t;

  // Table update request from the decision logic.
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] data;
  } upd_t;

endpackage

`default_nettype wire

### src/fdf_cfg_regs.sv
// Configuration registers of the flood relay duplicate filter.
// Depends on fdf_pkg for register indexes and reset values.
`default_nettype none

module fdf_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic      [fdf_pkg::BYTE_W-1:0]     own_system_id,
  output logic      [fdf_pkg::BYTE_W-1:0]     header_length
);
  import fdf_pkg::*;

  // Every write is taken as soon as it is offered, so the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_system_id <= OWN_SYSTEM_ID_RESET;
      header_length <= HEADER_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_SYSTEM_ID: own_system_id <= cfg_data;
        REG_HEADER_LENGTH: header_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/fdf_id_table.sv
// Last-seen message id table, one entry per source node.
// A RAM with registered read, per-entry valid bits cleared by reset, and
// write-to-read forwarding. Depends on fdf_pkg.
`default_nettype none

module fdf_id_table #(
  parameter  int NODE_COUNT = fdf_pkg::NODE_COUNT_DEFAULT,
  localparam int IdxW       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [IdxW-1:0]           rd_addr,
  output logic      [fdf_pkg::ID_W-1:0]  rd_data,
  input  wire logic                      wr_en,
  input  wire logic [IdxW-1:0]           wr_addr,
  input  wire logic [fdf_pkg::ID_W-1:0]  wr_data
);
  import fdf_pkg::*;

  logic [ID_W-1:0]       mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] entry_valid;

  logic [ID_W-1:0] rd_raw;
  logic [ID_W-1:0] byp_data;
  logic            byp_hit;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // The RAM returns the old word when a write lands on the address being
  // read, so the new word is captured on the side and takes precedence.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_hit  <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
      rd_valid <= entry_valid[rd_addr];
    end
  end

  assign rd_data = byp_hit  ? byp_data :
                   rd_valid ? rd_raw   : '0;

endmodule

`default_nettype wire

### src/fdf_judge.sv
// Decision logic of the flood relay duplicate filter.
// Runs the header checks in priority order and forms the table update.
// Depends on fdf_pkg.
`default_nettype none

module fdf_judge #(
  parameter int NODE_COUNT = fdf_pkg::NODE_COUNT_DEFAULT
) (
  input  wire fdf_pkg::hdr_t                  hdr,
  input  wire logic [fdf_pkg::BYTE_W-1:0]     own_system_id,
  input  wire logic [fdf_pkg::BYTE_W-1:0]     header_length,
  input  wire logic [fdf_pkg::ID_W-1:0]       stored_id,
  output fdf_pkg::result_t                    result,
  output fdf_pkg::upd_t                       upd
);
  import fdf_pkg::*;

  localparam logic [BYTE_W:0] NodeLimit = (BYTE_W + 1)'(NODE_COUNT);

  logic src_ok;

  assign src_ok = {1'b0, hdr.source_node} < NodeLimit;

  always_comb begin
    result.forward  = 1'b0;
    result.hops_out = hdr.hops_left;
    if (hdr.packet_length <= header_length) begin
      result.verdict = VERDICT_TOO_SHORT;
    end else if (hdr.packet_system_id != own_system_id) begin
      result.verdict = VERDICT_OTHER_SYS;
    end else if (!src_ok) begin
      result.verdict = VERDICT_BAD_SRC;
    end else if (hdr.hops_left == '0) begin
      result.verdict = VERDICT_NO_HOPS;
    end else if (hdr.message_number <= stored_id) begin
      // An id equal to the stored one counts as a repeat.
      result.verdict = VERDICT_STALE;
    end else begin
      result.verdict  = VERDICT_ACCEPT;
      result.forward  = 1'b1;
      result.hops_out = hdr.hops_left - 8'd1;
    end
  end

  assign upd.en   = result.forward;
  assign upd.data = (hdr.message_kind == KIND_RESET_ID) ? '0 : hdr.message_number;

endmodule

`default_nettype wire

### src/flood_relay_duplicate_filter_unit.sv
// Top level of the flood relay duplicate filter.
// Instantiates fdf_cfg_regs, fdf_id_table and fdf_judge; depends on fdf_pkg.
`default_nettype none

// The unit takes one packet header word per cycle while the output does not
// stall and returns one decision word per header, in order. A header is
// accepted on the input stream, its source entry is read from the last-seen id
// table in the same cycle, and in the next cycle the checks run against the
// registered header and table word; the decision lands in the output register.
// The header is registered into the decision stage at the input handshake and
// the decision into the output register when that stage advances; from there
// it is on the output stream. The id table has a single read and a single write
// port. Headers from the same source may follow each other
// in consecutive cycles: a table write forwards straight into a read of the
// same entry. The table is cleared by reset through per-entry valid bits, so
// no clearing pass is needed and the unit accepts input right after reset.
// The output register lets a new header enter while the previous decision
// waits for the downstream side; backpressure there stalls the whole unit.
// Configuration (own system id, minimum header length) is written through a
// separate port that never stalls and is meant to be written while the unit
// is idle. Writes to an index outside the register list are ignored.

module flood_relay_duplicate_filter_unit #(
  parameter int NODE_COUNT = fdf_pkg::NODE_COUNT_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream: one packet header per word.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: packet_length[7:0], packet_system_id[15:8],
  // source_node[23:16], hops_left[31:24], message_number[47:32],
  // message_kind[55:48].
  input  wire logic [fdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream: one decision per header.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: forward[0], hops_out[8:1], verdict[11:9], zero[15:12].
  output logic      [fdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fdf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fdf_pkg::*;

  localparam int IdxW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [BYTE_W:0] NodeLimit = (BYTE_W + 1)'(NODE_COUNT);

  logic [BYTE_W-1:0] own_system_id;
  logic [BYTE_W-1:0] header_length;

  hdr_t in_hdr;
  logic in_accept;
  logic [IdxW-1:0] rd_addr;

  // Decision stage registers and the signals formed from them.
  logic      s1_valid;
  hdr_t      s1_hdr;
  logic      s1_adv;
  logic [ID_W-1:0] stored_id;
  result_t   s1_result;
  upd_t      s1_upd;

  // Output register.
  logic      out_valid;
  result_t   out_result;

  fdf_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .own_system_id (own_system_id),
    .header_length (header_length)
  );

  assign in_hdr = hdr_t'(s_axis_tdata);

  // The decision stage moves on when the output register is free or drains.
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Sources outside the table read entry zero; their word is never used.
  assign rd_addr = ({1'b0, in_hdr.source_node} < NodeLimit) ?
                   in_hdr.source_node[IdxW-1:0] : '0;

  fdf_id_table #(
    .NODE_COUNT (NODE_COUNT)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (stored_id),
    .wr_en   (s1_adv && s1_upd.en),
    .wr_addr (s1_hdr.source_node[IdxW-1:0]),
    .wr_data (s1_upd.data)
  );

  fdf_judge #(
    .NODE_COUNT (NODE_COUNT)
  ) u_judge (
    .hdr           (s1_hdr),
    .own_system_id (own_system_id),
    .header_length (header_length),
    .stored_id     (stored_id),
    .result        (s1_result),
    .upd           (s1_upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hdr <= in_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result <= s1_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_result.verdict, out_result.hops_out,
                          out_result.forward};

endmodule

`default_nettype wire

### src/fdf_checker.sv
// Port-level checker for the flood relay duplicate filter, and its bind.
// Depends on fdf_pkg and on the top level flood_relay_duplicate_filter_unit.
`default_nettype none

module fdf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [fdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fdf_pkg::*;

  // A decision that is being held stays on the output stream and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // Forward is set exactly when the verdict is accept.
  a_fwd_verdict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[0] == (m_axis_tdata[11:9] == VERDICT_ACCEPT)))
    else $error("forward flag disagrees with verdict");

  // Only defined verdict codes come out, with zero padding above them.
  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[11:9] <= VERDICT_STALE) &&
                      (m_axis_tdata[15:12] == 4'b0000))
    else $error("undefined verdict code or nonzero padding");

  // A word accepted while the output is empty and ready comes out through the decision stage and output register.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready && m_axis_tready
      |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after accept");

  // No result comes out of reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind flood_relay_duplicate_filter_unit fdf_checker u_fdf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for flood_relay_duplicate_filter_unit.
// Holds a scoreboard class that predicts each decision word; depends on fdf_pkg and the RTL.
`default_nettype none

module tb_top;
  import fdf_pkg::*;

  // A window this long with no handshake at all means the unit has hung.
  localparam int QUIET_LIMIT = 1000;
  // First index past the end of the register list; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LAST = CFG_IDX_W'(2);
  localparam int NODES = NODE_COUNT_DEFAULT;
  localparam int NODE_IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum int {RX_STEADY, RX_CHOPPY, RX_BLOCKY} rx_mode_t;

  // Tracks the relay's filter state and the decisions still owed by the unit.
  class relay_decision_model;
    logic [BYTE_W-1:0] own_sys;
    logic [BYTE_W-1:0] min_len;
    logic [ID_W-1:0]   last_id [NODES];
    result_t           due_q [$];
    int                failures;

    function new();
      own_sys  = OWN_SYSTEM_ID_RESET;
      min_len  = HEADER_LENGTH_RESET;
      failures = 0;
      foreach (last_id[i]) last_id[i] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_OWN_SYSTEM_ID) begin
        own_sys = val;
      end else if (idx == REG_HEADER_LENGTH) begin
        min_len = val;
      end
    endfunction

    // The checks run in a fixed order and the first failing one decides.
    function void note_header(hdr_t h);
      result_t r;
      r.forward  = 1'b0;
      r.hops_out = h.hops_left;
      if (h.packet_length <= min_len) begin
        r.verdict = VERDICT_TOO_SHORT;
      end else if (h.packet_system_id != own_sys) begin
        r.verdict = VERDICT_OTHER_SYS;
      end else if (int'(h.source_node) >= NODES) begin
        r.verdict = VERDICT_BAD_SRC;
      end else if (h.hops_left == '0) begin
        r.verdict = VERDICT_NO_HOPS;
      end else if (h.message_number <= last_id[h.source_node[NODE_IDX_W-1:0]]) begin
        r.verdict = VERDICT_STALE;
      end else begin
        // A reset-kind message clears the entry but is still relayed.
        last_id[h.source_node[NODE_IDX_W-1:0]] =
          (h.message_kind == KIND_RESET_ID) ? '0 : h.message_number;
        r.forward  = 1'b1;
        r.hops_out = h.hops_left - 8'd1;
        r.verdict  = VERDICT_ACCEPT;
      end
      due_q.push_back(r);
    endfunction

    function void check_decision(logic [OUT_TDATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[$bits(result_t)-1:0]);
      if (due_q.size() == 0) begin
        $error("decision word %h arrived with no header pending", word);
        failures++;
        return;
      end
      want = due_q.pop_front();
      if (got.forward !== want.forward) begin
        $error("forward: expected %0d, got %0d", want.forward, got.forward);
        failures++;
      end
      if (got.hops_out !== want.hops_out) begin
        $error("hops_out: expected %0d, got %0d", want.hops_out, got.hops_out);
        failures++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        failures++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  relay_decision_model sb = new();

  // Sender burst shaping and receiver stall pattern.
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_run = 0;
  logic     rx_level = 1'b1;
  int       quiet_cycles = 0;

  flood_relay_duplicate_filter_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Output side: check every accepted decision word, then pick the next
  // ready level. Sampling happens before this edge's updates land.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_decision(m_axis_tdata);
    end
    if (rx_run == 0) begin
      case (rx_mode)
        RX_STEADY: begin
          rx_level = 1'b1;
          rx_run   = $urandom_range(8, 40);
        end
        RX_CHOPPY: begin
          rx_level = 1'($urandom_range(0, 1));
          rx_run   = $urandom_range(1, 3);
        end
        default: begin
          rx_level = !rx_level;
          rx_run   = rx_level ? $urandom_range(1, 6) : $urandom_range(4, 16);
        end
      endcase
    end
    rx_run--;
    m_axis_tready <= rx_level;
  end

  // Watchdog: any handshake on any channel proves progress.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic hdr_t make_hdr(int len, int sys, int src, int hops, int id, int kind);
    hdr_t h;
    h.packet_length    = BYTE_W'(len);
    h.packet_system_id = BYTE_W'(sys);
    h.source_node      = BYTE_W'(src);
    h.hops_left        = BYTE_W'(hops);
    h.message_number   = ID_W'(id);
    h.message_kind     = BYTE_W'(kind);
    return h;
  endfunction

  // Mostly well-formed headers that reach the stale check, with a slice of
  // headers broken at one check and a slice of pure noise.
  function automatic hdr_t pick_header();
    hdr_t             h;
    logic [63:0]      noise;
    logic [ID_W-1:0]  seen;
    int               roll;
    roll  = $urandom_range(0, 99);
    noise = {$urandom, $urandom};
    h     = hdr_t'(noise[IN_TDATA_W-1:0]);
    if (roll < 15) return h;
    if (sb.min_len != 8'hFF) begin
      h.packet_length = BYTE_W'($urandom_range(int'(sb.min_len) + 1, 255));
    end
    h.packet_system_id = sb.own_sys;
    h.source_node      = BYTE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, NODES - 1)
                                                              : $urandom_range(0, 7));
    h.hops_left        = ($urandom_range(0, 7) == 0) ? 8'd1
                                                     : BYTE_W'($urandom_range(1, 255));
    h.message_kind     = ($urandom_range(0, 9) == 0) ? KIND_RESET_ID
                                                     : BYTE_W'($urandom_range(0, 255));
    seen = sb.last_id[h.source_node[NODE_IDX_W-1:0]];
    if (seen < 16'hFFC0) begin
      h.message_number = seen + ID_W'($urandom_range(1, 50));
    end
    if (roll < 25) begin
      case ($urandom_range(0, 3))
        0: h.packet_length = BYTE_W'($urandom_range(0, int'(sb.min_len)));
        1: h.packet_system_id = sb.own_sys ^ BYTE_W'($urandom_range(1, 255));
        2: h.source_node = BYTE_W'($urandom_range(NODES, 255));
        default: h.hops_left = '0;
      endcase
    end else if (roll < 37) begin
      // Equal or older id: stale.
      h.message_number = seen - ID_W'($urandom_range(0, (seen < 50) ? int'(seen) : 50));
    end else if (roll >= 92) begin
      h.message_number = ID_W'($urandom);
    end
    return h;
  endfunction

  task automatic send_header(input hdr_t h);
    if (burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_header(h);
    burst_left--;
  endtask

  // Stop sending and wait for every owed decision, then a short pause so
  // the pipeline is empty before any register changes.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Writes both registers plus one index past the list, which must be ignored.
  task automatic set_config(input int sys, input int len);
    cfg_write(REG_OWN_SYSTEM_ID, CFG_DATA_W'(sys));
    cfg_write(REG_BEYOND_LAST + CFG_IDX_W'($urandom_range(0, 253)), CFG_DATA_W'($urandom));
    cfg_write(REG_HEADER_LENGTH, CFG_DATA_W'(len));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sys;
    int len;
    int count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration (system 0, length 8).
    send_header(make_hdr(8, 0, 0, 1, 1, 0));        // length equal to the limit is short
    send_header(make_hdr(0, 0, 0, 1, 1, 0));
    send_header(make_hdr(9, 1, 0, 1, 1, 0));        // foreign system
    send_header(make_hdr(9, 0, NODES, 1, 1, 0));    // source right at the node count
    send_header(make_hdr(255, 0, 255, 1, 1, 0));
    send_header(make_hdr(9, 0, 0, 0, 1, 0));        // no hops left
    send_header(make_hdr(9, 0, 0, 1, 0, 0));        // id zero against an empty entry
    send_header(make_hdr(9, 0, 0, 1, 1, 0));        // accepted, leaves with zero hops
    send_header(make_hdr(9, 0, 0, 5, 1, 0));        // same id again is stale
    send_header(make_hdr(9, 0, 0, 5, 2, 0));        // same source, back-to-back unless a burst gap falls here
    send_header(make_hdr(255, 0, NODES - 1, 255, 65535, 255));
    send_header(make_hdr(255, 0, NODES - 1, 255, 65535, 0));
    send_header(make_hdr(200, 0, NODES - 1, 7, 3, KIND_RESET_ID)); // stale even as reset kind
    send_header(make_hdr(20, 0, 5, 3, 100, KIND_RESET_ID));        // accepted, entry cleared
    send_header(make_hdr(20, 0, 5, 3, 1, 0));       // id one passes after the clear
    drain();
    set_config(255, 0);
    send_header(make_hdr(0, 255, 1, 1, 1, 0));
    send_header(make_hdr(1, 255, 1, 1, 1, 0));
    send_header(make_hdr(1, 0, 1, 1, 2, 0));
    drain();
    set_config(8'hA5, 255);                        // nothing can be long enough
    send_header(make_hdr(255, 8'hA5, 2, 1, 1, 0));
    send_header(make_hdr(255, 8'h5A, 70, 0, 0, 0));
    drain();
    set_config(0, 254);
    send_header(make_hdr(255, 0, 2, 1, 1, 0));
    send_header(make_hdr(254, 0, 2, 1, 2, 0));

    // Random phases, each under its own configuration and idling style.
    for (int p = 0; p < 9; p++) begin
      drain();
      case (p % 3)
        0: sys = 0;
        1: sys = 255;
        default: sys = $urandom_range(0, 255);
      endcase
      case (p)
        0: len = 0;
        1: len = 254;
        2: len = 255;
        3: len = 8;
        default: len = $urandom_range(0, 60);
      endcase
      set_config(sys, len);
      gaps_on = (p % 4) != 1;
      rx_mode = rx_mode_t'(p % 3);
      count   = (len == 255) ? 40 : 150;
      repeat (count) send_header(pick_header());
    end

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/fdf_pkg.sv
src/fdf_cfg_regs.sv
src/fdf_id_table.sv
src/fdf_judge.sv
src/flood_relay_duplicate_filter_unit.sv
src/fdf_checker.sv
verif/tb_top.sv
